// ===== rtl/ssp_pkg.sv =====
// Shared types, register indexes and the master clock divider table of the SPI peripheral.
package ssp_pkg;

    localparam int DATA_BITS_DEF = 8;
    localparam int BYTE_BITS     = 8;
    localparam int DIV_W         = 7;
    localparam int ADDR_W        = 5;
    localparam int APB_DATA_W    = 32;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 16;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_MASTER     = 3'd1;
    localparam logic [2:0] REG_LSB_FIRST  = 3'd2;
    localparam logic [2:0] REG_CPOL       = 3'd3;
    localparam logic [2:0] REG_CPHA       = 3'd4;
    localparam logic [2:0] REG_RATE       = 3'd5;
    localparam logic [2:0] REG_IRQ_EN     = 3'd6;

    typedef struct packed {
        logic       enable;
        logic       master_mode;
        logic       lsb_first;
        logic       clock_polarity;
        logic       clock_phase;
        logic [2:0] rate_select;
        logic       interrupt_enable;
    } t_cfg;

    typedef struct packed {
        t_op        operation;
        logic [7:0] write_data;
        logic       miso_in;
        logic       mosi_in;
        logic       sck_in;
        logic       select_n_in;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       sck_out;
        logic       mosi_out;
        logic       miso_out;
    } t_result;

    // Half period of the master clock in items, indexed by {spi2x, spr1, spr0}.
    function automatic logic [DIV_W-1:0] half_period(input logic [2:0] code);
        logic [DIV_W-1:0] hp;
        case (code)
            3'd0:    hp = 7'd2;
            3'd1:    hp = 7'd8;
            3'd2:    hp = 7'd32;
            3'd3:    hp = 7'd64;
            3'd4:    hp = 7'd1;
            3'd5:    hp = 7'd4;
            3'd6:    hp = 7'd16;
            default: hp = 7'd32;
        endcase
        return hp;
    endfunction

endpackage

// ===== rtl/spi_serial_peripheral_top.sv =====
// Top level of the byte-wide SPI peripheral: stream ports, APB registers and output register.
//
// Each input item is one update step of the peripheral and carries a bus
// access (none, data write, data read, status read) together with the sampled serial
// pin levels; each item yields exactly one result item with the read data, the
// interrupt and the driven pin levels. One item is accepted every clock cycle while
// the input side is not stalled: the whole update of the transfer engine is a single
// combinational pass from its state registers into the output register, where the
// result is registered as its item is taken. The input side stalls only while the
// output register holds a result that the downstream side has not taken. In master
// mode the serial clock toggle interval is set by the rate register; in slave mode the
// serial clock goes through a synchronizer, so an edge is acted on with the next item.
module spi_serial_peripheral_top #(
    parameter int DATA_BITS = ssp_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssp_pkg::ADDR_W-1:0]     paddr,
    input  logic [ssp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ssp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // write_data[7:0], miso_in[8], mosi_in[9], sck_in[10], select_n_in[11], zero[15:12]
    input  logic [ssp_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [1:0]                     s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data[7:0], irq[8], sck_out[9], mosi_out[10], miso_out[11], zero[15:12]
    output logic [ssp_pkg::OUT_DATA_W-1:0] m_tdata
);

    ssp_pkg::t_cfg    cfg;
    ssp_pkg::t_item   item;
    ssp_pkg::t_result result;
    logic             abort;
    logic             step;

    logic             r_out_valid;
    ssp_pkg::t_result r_out;

    assign s_tready = i_rst_n && (!r_out_valid || m_tready);
    assign step     = s_tvalid && s_tready;

    assign item.operation   = ssp_pkg::t_op'(s_tuser);
    assign item.write_data  = s_tdata[7:0];
    assign item.miso_in     = s_tdata[8];
    assign item.mosi_in     = s_tdata[9];
    assign item.sck_in      = s_tdata[10];
    assign item.select_n_in = s_tdata[11];

    ssp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_abort (abort)
    );

    ssp_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_abort  (abort),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out.miso_out, r_out.mosi_out, r_out.sck_out, r_out.irq,
                       r_out.read_data};

endmodule

// ===== rtl/ssp_cfg.sv =====
// APB register bank of the SPI peripheral, with the abort request on enable or mode change.
module ssp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssp_pkg::ADDR_W-1:0]     paddr,
    input  logic [ssp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ssp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ssp_pkg::t_cfg                  o_cfg,
    output logic                           o_abort
);

    ssp_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[ssp_pkg::ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Toggling enable or mode kills a transfer in flight.
    assign o_abort = wr_en &&
                     (((index == ssp_pkg::REG_ENABLE) && (pwdata[0] != r_cfg.enable)) ||
                      ((index == ssp_pkg::REG_MASTER) && (pwdata[0] != r_cfg.master_mode)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (index)
                ssp_pkg::REG_ENABLE:    r_cfg.enable           <= pwdata[0];
                ssp_pkg::REG_MASTER:    r_cfg.master_mode      <= pwdata[0];
                ssp_pkg::REG_LSB_FIRST: r_cfg.lsb_first        <= pwdata[0];
                ssp_pkg::REG_CPOL:      r_cfg.clock_polarity   <= pwdata[0];
                ssp_pkg::REG_CPHA:      r_cfg.clock_phase      <= pwdata[0];
                ssp_pkg::REG_RATE:      r_cfg.rate_select      <= pwdata[2:0];
                ssp_pkg::REG_IRQ_EN:    r_cfg.interrupt_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (index)
            ssp_pkg::REG_ENABLE:    prdata[0]   = r_cfg.enable;
            ssp_pkg::REG_MASTER:    prdata[0]   = r_cfg.master_mode;
            ssp_pkg::REG_LSB_FIRST: prdata[0]   = r_cfg.lsb_first;
            ssp_pkg::REG_CPOL:      prdata[0]   = r_cfg.clock_polarity;
            ssp_pkg::REG_CPHA:      prdata[0]   = r_cfg.clock_phase;
            ssp_pkg::REG_RATE:      prdata[2:0] = r_cfg.rate_select;
            ssp_pkg::REG_IRQ_EN:    prdata[0]   = r_cfg.interrupt_enable;
            default: ;
        endcase
    end

endmodule

// ===== rtl/ssp_engine.sv =====
// Transfer engine: shift register, bit counter, master divider and slave clock synchronizer.
module ssp_engine #(
    parameter int DATA_BITS = ssp_pkg::DATA_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_abort,
    input  ssp_pkg::t_item   i_item,
    input  ssp_pkg::t_cfg    i_cfg,
    output ssp_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(DATA_BITS + 1);
    localparam int MSB   = DATA_BITS - 1;

    logic [DATA_BITS-1:0]      r_shift, n_shift;
    logic [DATA_BITS-1:0]      r_hold, n_hold;
    logic [CNT_W-1:0]          r_bits, n_bits;
    logic [ssp_pkg::DIV_W-1:0] r_div, n_div;
    logic                      r_lvl, n_lvl;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic                      r_coll, n_coll;
    logic                      r_seen, n_seen;
    logic [1:0]                r_sync, n_sync;
    logic                      r_line, n_line;

    logic                 edge_hit;
    logic                 leading;
    logic                 din;
    logic                 top;
    logic                 level;
    logic [DATA_BITS-1:0] shifted;
    logic [7:0]           rd;

    always_comb begin
        n_shift = r_shift;
        n_hold  = r_hold;
        n_bits  = r_bits;
        n_div   = r_div;
        n_lvl   = r_lvl;
        n_busy  = r_busy;
        n_done  = r_done;
        n_coll  = r_coll;
        n_seen  = r_seen;
        n_sync  = r_sync;
        n_line  = r_line;
        edge_hit = 1'b0;
        leading  = 1'b0;
        din      = 1'b0;
        level    = 1'b0;
        top      = 1'b0;
        shifted  = '0;

        // Reads show the values held before this item's update.
        rd = '0;
        case (i_item.operation)
            ssp_pkg::OP_READ:   rd = r_hold[7:0];
            ssp_pkg::OP_STATUS: rd = {r_done, r_coll, 6'd0};
            default: ;
        endcase

        // A status read that sees a flag arms the clear; the next data access clears.
        if ((i_item.operation == ssp_pkg::OP_STATUS) && (r_done || r_coll)) begin
            n_seen = 1'b1;
        end
        if (((i_item.operation == ssp_pkg::OP_WRITE) || (i_item.operation == ssp_pkg::OP_READ))
            && r_seen) begin
            n_done = 1'b0;
            n_coll = 1'b0;
            n_seen = 1'b0;
        end

        if ((i_item.operation == ssp_pkg::OP_WRITE) && i_cfg.enable) begin
            if (r_busy) begin
                n_coll = 1'b1;
            end else begin
                n_shift = DATA_BITS'(i_item.write_data);
                n_line  = i_cfg.lsb_first ? n_shift[0] : n_shift[MSB];
                if (i_cfg.master_mode) begin
                    n_busy = 1'b1;
                    n_bits = '0;
                    n_div  = '0;
                    n_lvl  = 1'b0;
                end
            end
        end

        if (!i_cfg.enable) begin
            n_busy = 1'b0;
            n_bits = '0;
            n_div  = '0;
            if (i_cfg.master_mode) begin
                n_lvl = 1'b0;
            end
        end

        if (i_cfg.master_mode) begin
            din = i_item.miso_in;
            if (i_cfg.enable && n_busy) begin
                n_div = n_div + 1'b1;
                if (n_div >= ssp_pkg::half_period(i_cfg.rate_select)) begin
                    n_div    = '0;
                    n_lvl    = ~n_lvl;
                    edge_hit = 1'b1;
                    leading  = n_lvl;
                end
            end
        end else begin
            // The synchronizer runs even while disabled so that no stale edge appears later.
            din    = i_item.mosi_in;
            level  = r_sync[0];
            n_sync = {r_sync[0], i_item.sck_in};
            n_lvl  = level;
            if (i_cfg.enable) begin
                if (i_item.select_n_in) begin
                    n_busy = 1'b0;
                    n_bits = '0;
                end else if (level != r_lvl) begin
                    n_busy   = 1'b1;
                    edge_hit = 1'b1;
                    leading  = level ^ i_cfg.clock_polarity;
                end
            end
        end

        if (edge_hit) begin
            top     = i_cfg.lsb_first ? n_shift[0] : n_shift[MSB];
            shifted = i_cfg.lsb_first ? {din, n_shift[MSB:1]} : {n_shift[MSB-1:0], din};
            if (leading) begin
                if (i_cfg.clock_phase) begin
                    n_line = top;
                end else begin
                    n_shift = shifted;
                end
            end else begin
                if (i_cfg.clock_phase) begin
                    n_shift = shifted;
                end else begin
                    n_line = top;
                end
                n_bits = n_bits + 1'b1;
                if (n_bits >= CNT_W'(DATA_BITS)) begin
                    n_busy = 1'b0;
                    n_bits = '0;
                    n_div  = '0;
                    n_hold = n_shift;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_result.read_data = rd;
        o_result.irq       = n_done & i_cfg.interrupt_enable;
        o_result.sck_out   = (i_cfg.enable && i_cfg.master_mode) ?
                             (i_cfg.clock_polarity ^ n_lvl) : 1'b0;
        o_result.mosi_out  = (i_cfg.enable && i_cfg.master_mode) ? n_line : 1'b0;
        o_result.miso_out  = (i_cfg.enable && !i_cfg.master_mode && !i_item.select_n_in) ?
                             n_line : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_hold  <= '0;
            r_bits  <= '0;
            r_div   <= '0;
            r_lvl   <= 1'b0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_coll  <= 1'b0;
            r_seen  <= 1'b0;
            r_sync  <= '0;
            r_line  <= 1'b0;
        end else if (i_abort) begin
            r_busy <= 1'b0;
            r_bits <= '0;
            r_div  <= '0;
            r_lvl  <= 1'b0;
        end else if (i_step) begin
            r_shift <= n_shift;
            r_hold  <= n_hold;
            r_bits  <= n_bits;
            r_div   <= n_div;
            r_lvl   <= n_lvl;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_coll  <= n_coll;
            r_seen  <= n_seen;
            r_sync  <= n_sync;
            r_line  <= n_line;
        end
    end

endmodule

// ===== rtl/ssp_checker.sv =====
// Port-level checks of the SPI peripheral, bound to its top level.
module ssp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ssp_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic accept;
    assign accept = s_tvalid && s_tready;

    // A result that is not taken stays on the bus unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // The input side is never blocked while the output register is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // Every accepted item shows its result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_tvalid)
        else $error("accepted item gave no result");

    // No read data unless the item was a read; status has only two live bits.
    a_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((s_tuser == ssp_pkg::OP_NONE) || (s_tuser == ssp_pkg::OP_WRITE)))
        |=> (m_tdata[7:0] == 8'd0))
        else $error("read data on a non-read item");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_tuser == ssp_pkg::OP_STATUS)) |=> (m_tdata[5:0] == 6'd0))
        else $error("status reserved bits set");

endmodule

bind spi_serial_peripheral_top ssp_checker u_ssp_checker (.*);
